// ===== hw/rtl/pwg_pkg.sv =====
// Package of the periodic waveform generator core.
// Field widths, register indexes, shape codes and the controller/datapath link types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package pwg_pkg;

    localparam int IDX_W           = 17;   // point index and period length
    localparam int AMP_W           = 16;   // amplitude and sample
    localparam int SHAPE_W         = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;
    localparam int SINE_TABLE_DEF  = 1024;

    localparam logic [SHAPE_W-1:0] SHAPE_RST  = 2'd0;
    localparam logic [AMP_W-1:0]   AMP_RST    = 16'hFFFF;
    localparam logic [IDX_W-1:0]   PERIOD_RST = 17'd870;
    localparam logic [AMP_W-1:0]   AMP_MAX    = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

    // Wave shape codes
    localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW    = 2'd3;

    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic setup;      // latch operands for the current point
        logic mul;        // multiply and load the divider
        logic second;     // sine scaling pass: use table word and amplitude
        logic div_step;   // one restoring division step
        logic look;       // read the sine table
        logic load_out;   // move the result into the output register
    } pwg_cmd_t;

    typedef struct packed {
        logic is_square;
        logic is_sine;
        logic div_last;
        logic out_free;
    } pwg_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pwg_ctrl.sv =====
// Sequencer of the periodic waveform generator core.
// Steps points via setup and, per shape, multiply, serial divide, lookup.
// Depends on pwg_pkg for the command and status types.
`default_nettype none

module pwg_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire pwg_pkg::pwg_stat_t  stat,
    output pwg_pkg::pwg_cmd_t        cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_LOOK  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    pass_next  = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.is_square ? ST_FIN : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cmd.second = pass_reg;
                // the sine scaling pass is finished by the multiply itself
                state_next = pass_reg ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = (stat.is_sine && !pass_reg) ? ST_LOOK : ST_FIN;
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                pass_next  = 1'b1;
                state_next = ST_MUL;
            end
            ST_FIN:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_look_first_pass: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> !pass_reg)
        else $error("table lookup on the scaling pass");

    a_fin_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && stat.div_last |=> state_reg == ST_LOOK || state_reg == ST_FIN)
        else $error("divider end not followed by lookup or finish");

endmodule

`default_nettype wire

// ===== hw/rtl/pwg_dp.sv =====
// Datapath of the periodic waveform generator core.
// Config registers, point index, shared multiplier, serial divider, sine ROM, output register.
// Depends on pwg_pkg; driven by pwg_ctrl through command and status structs.
`default_nettype none

module pwg_dp
#(
    parameter int SINE_TABLE_SIZE = pwg_pkg::SINE_TABLE_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [pwg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [pwg_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pwg_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tlast,
    input  wire pwg_pkg::pwg_cmd_t                 cmd,
    output pwg_pkg::pwg_stat_t                     stat
);

    localparam int IDX_W = pwg_pkg::IDX_W;
    localparam int AMP_W = pwg_pkg::AMP_W;
    localparam int PW    = $clog2(SINE_TABLE_SIZE);          // table address
    localparam int TW    = $clog2(SINE_TABLE_SIZE + 1);      // table size value
    localparam int OPB_W = (TW > AMP_W) ? TW : AMP_W;
    localparam int NUM_W = IDX_W + OPB_W;
    localparam int QW    = (PW > AMP_W) ? PW : AMP_W;        // quotient bits
    localparam int DEN_W = IDX_W;
    localparam int CNT_W = $clog2(QW);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef logic [AMP_W-1:0] rom_t [SINE_TABLE_SIZE];

    // Table entry: 8-term series for sin or cos over one quadrant, Q30 fixed point
    function automatic logic [AMP_W-1:0] sine_entry(input int unsigned p);
        longint unsigned k, r, theta, t2, term, x, pos, neg, s, v, e;
        logic            cosf;
        k     = (64'd4 * 64'(p)) / SINE_TABLE_SIZE;
        r     = (64'd4 * 64'(p)) % SINE_TABLE_SIZE;
        theta = (PI_Q30 * r) / (2 * SINE_TABLE_SIZE);
        t2    = (theta * theta) >> 30;
        cosf  = k[0];
        term  = cosf ? ONE_Q30 : theta;
        pos   = 64'd0;
        neg   = 64'd0;
        for (int n = 0; n < 8; n++)
        begin
            if (n % 2 == 0)
                pos = pos + term;
            else
                neg = neg + term;
            x = (term * t2) >> 30;
            case (n)
                0: term = cosf ? x / 2   : x / 6;
                1: term = cosf ? x / 12  : x / 20;
                2: term = cosf ? x / 30  : x / 42;
                3: term = cosf ? x / 56  : x / 72;
                4: term = cosf ? x / 90  : x / 110;
                5: term = cosf ? x / 132 : x / 156;
                6: term = cosf ? x / 182 : x / 210;
                default: term = cosf ? x / 240 : x / 272;
            endcase
        end
        if (neg >= pos)
            s = 64'd0;
        else
            s = (pos - neg > ONE_Q30) ? ONE_Q30 : pos - neg;
        v = (k < 2) ? (ONE_Q30 + s) / 2 : (ONE_Q30 - s) / 2;
        e = (v * 64'd65535 + (64'd1 << 29)) >> 30;
        return (e > 64'd65535) ? pwg_pkg::AMP_MAX : e[AMP_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int p = 0; p < SINE_TABLE_SIZE; p++)
            tbl[p] = sine_entry(p);
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration
    logic [pwg_pkg::SHAPE_W-1:0] shape_reg;
    logic [AMP_W-1:0]            amp_reg;
    logic [IDX_W-1:0]            period_reg;

    // Point and operands
    logic [IDX_W-1:0] index_reg, index_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] half_reg;
    logic             end_reg, end_next;
    logic [IDX_W-1:0] op_a_reg;
    logic [OPB_W-1:0] op_b_reg;
    logic [DEN_W-1:0] den_reg;
    logic [AMP_W-1:0] sq_reg;
    logic [AMP_W-1:0] rom_data_reg;

    // Divider
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    logic [IDX_W-1:0] mul_a;
    logic [OPB_W-1:0] mul_b;
    logic [NUM_W-1:0] prod;
    logic [NUM_W-1:0] scale_sum;
    logic [PW-1:0]    phase;
    logic             is_tri, is_sine, is_square;

    // Output register
    logic                    m_tvalid_reg;
    logic [AMP_W-1:0]        m_tdata_reg;
    logic                    m_tlast_reg;

    assign is_tri    = shape_reg == pwg_pkg::SHAPE_TRI;
    assign is_sine   = shape_reg == pwg_pkg::SHAPE_SINE;
    assign is_square = shape_reg == pwg_pkg::SHAPE_SQUARE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= pwg_pkg::SHAPE_RST;
            amp_reg    <= pwg_pkg::AMP_RST;
            period_reg <= pwg_pkg::PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pwg_pkg::REG_SHAPE:  shape_reg  <= cfg_data[pwg_pkg::SHAPE_W-1:0];
                pwg_pkg::REG_AMP:    amp_reg    <= cfg_data[AMP_W-1:0];
                pwg_pkg::REG_PERIOD: period_reg <= cfg_data[IDX_W-1:0];
                default:             ;
            endcase
        end
    end

    // Accept: clamp a short period and fold a stale or restarted index to zero; setup: flag period end, advance index
    always_comb
    begin
        n_next = (period_reg < IDX_W'(2)) ? IDX_W'(2) : period_reg;
        if (s_tdata[0] || index_reg >= n_next)
            i_next = '0;
        else
            i_next = index_reg;
        end_next   = i_reg == n_reg - IDX_W'(1);
        index_next = end_next ? '0 : i_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= '0;
        else if (cmd.setup)
            index_reg <= index_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            i_reg    <= i_next;
            n_reg    <= n_next;
            half_reg <= n_next >> 1;
        end
        if (cmd.setup)
        begin
            end_reg  <= end_next;
            op_a_reg <= (is_tri && i_reg >= half_reg) ? n_reg - IDX_W'(1) - i_reg : i_reg;
            op_b_reg <= is_sine ? OPB_W'(SINE_TABLE_SIZE) : OPB_W'(amp_reg);
            den_reg  <= is_tri ? half_reg : n_reg;
            sq_reg   <= (i_reg < half_reg) ? '0 : amp_reg;
        end
        if (cmd.look)
            rom_data_reg <= SINE_ROM[phase];
    end

    // Clamp the phase to the last table entry
    assign phase = (q_reg >= QW'(SINE_TABLE_SIZE)) ? PW'(SINE_TABLE_SIZE - 1) : q_reg[PW-1:0];

    // Shared multiplier feeds the divider directly; on the sine scaling pass its scaled product goes to q_reg
    assign mul_a = cmd.second ? IDX_W'(rom_data_reg) : op_a_reg;
    assign mul_b = cmd.second ? OPB_W'(amp_reg) : op_b_reg;
    assign prod  = {{OPB_W{1'b0}}, mul_a} * {{IDX_W{1'b0}}, mul_b};

    // Divide the sine product by full scale: x / 65535 = (x + x / 65536 + 1) / 65536
    // holds for every product of two 16-bit values
    assign scale_sum = prod + (prod >> AMP_W) + NUM_W'(1);

    // Restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, q_reg[QW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    assign q_next   = {q_reg[QW-2:0], ge};

    always_ff @(posedge clk)
    begin
        if (cmd.mul && cmd.second)
        begin
            q_reg   <= QW'(scale_sum >> AMP_W);
        end
        else if (cmd.mul)
        begin
            rem_reg <= DEN_W'(prod >> QW);
            q_reg   <= prod[QW-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.mul)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= is_square ? sq_reg : q_reg[AMP_W-1:0];
            m_tlast_reg <= end_reg;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = m_tdata_reg;
    assign m_tlast        = m_tlast_reg;
    assign stat.is_square = is_square;
    assign stat.is_sine   = is_sine;
    assign stat.div_last  = cnt_reg == CNT_W'(QW - 1);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> den_reg != '0)
        else $error("divide by zero");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < den_reg)
        else $error("partial remainder out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !m_tvalid_reg || m_tready)
        else $error("output word overwritten");

    a_wrap_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup ##1 end_reg |-> index_reg == '0)
        else $error("index not wrapped at period end");

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_waveform_generator_core.sv =====
// Periodic waveform generator: one 16-bit DAC sample per input word.
// Channels: s_* takes one word per sample request, bit 0 of s_tdata asks for a
//   restart at point 0. m_* returns the sample in m_tdata, with m_tlast set on
//   the last point of the period. cfg_* writes shape (0), amplitude (1) and
//   period length (2); cfg_ready is always high, other indexes are dropped.
// Write configuration only while no sample is in flight.
// Square words go from setup straight to the output register. Triangle and
//   sawtooth run the serial divider, QW = max(16, clog2(SINE_TABLE_SIZE)) steps
//   of one quotient bit per cycle; sine adds a table read and a scaling multiply.
// A new word is taken only after the previous result has entered the output
//   register, so the computation of a word never overlaps the previous one.
// Reset loads shape sine, amplitude 65535, period 870 and point index 0; the
//   sine table is a constant ROM and needs no fill time.
// A stalled receiver holds the result in the output register; one more word is
//   taken and computed, then s_tready stays low until the register drains.
// Depends on pwg_pkg, pwg_ctrl and pwg_dp.
`default_nettype none

module periodic_waveform_generator_core
#(
    parameter int SINE_TABLE_SIZE = pwg_pkg::SINE_TABLE_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pwg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pwg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pwg_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [15:0] sample
    output logic                                   m_tlast    // period end
);

    pwg_pkg::pwg_cmd_t  cmd;
    pwg_pkg::pwg_stat_t stat;

    assign cfg_ready = 1'b1;

    pwg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwg_dp
    #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== test/tb_periodic_waveform_generator_core.sv =====
// Self-checking testbench for periodic_waveform_generator_core.
// Drives sample requests and register writes and checks every output word
// against a cycle-free predictor. Depends on pwg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_periodic_waveform_generator_core;

    localparam int IDX_W       = pwg_pkg::IDX_W;
    localparam int AMP_W       = pwg_pkg::AMP_W;
    localparam int SHAPE_W     = pwg_pkg::SHAPE_W;
    localparam int CFG_IDX_W   = pwg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = pwg_pkg::CFG_DATA_W;
    localparam int IN_TDATA_W  = pwg_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = pwg_pkg::OUT_TDATA_W;

    localparam longint unsigned TABLE_LEN   = pwg_pkg::SINE_TABLE_DEF;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam int              ITEM_TARGET = 1850;
    localparam int              CALM_ITEMS  = 150;
    localparam int              SETTLE      = 50;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [AMP_W-1:0] sample;
        logic             period_end;
    } dac_word_t;

    class sample_predictor;
        logic [SHAPE_W-1:0] shape;
        logic [AMP_W-1:0]   amp;
        logic [IDX_W-1:0]   period;
        logic [IDX_W-1:0]   point;
        logic [AMP_W-1:0]   sine_rom [TABLE_LEN];
        dac_word_t          expected_samples [$];
        int                 errors;

        function new();
            shape  = pwg_pkg::SHAPE_RST;
            amp    = pwg_pkg::AMP_RST;
            period = pwg_pkg::PERIOD_RST;
            point  = '0;
            errors = 0;
            for (int p = 0; p < TABLE_LEN; p++)
                sine_rom[p] = rom_entry(p);
        endfunction

        // Alternating Taylor sum in Q30, eight terms, clamped to [0, 1].
        function longint unsigned taylor_q30(longint unsigned theta, bit use_cos);
            longint unsigned t2, term, pos, neg, d;
            t2   = (theta * theta) >> 30;
            term = use_cos ? ONE_Q30 : theta;
            pos  = 0;
            neg  = 0;
            for (longint unsigned k = 0; k < 8; k++)
            begin
                d = use_cos ? (2 * k + 1) * (2 * k + 2) : (2 * k + 2) * (2 * k + 3);
                if (k[0] == 1'b0)
                    pos += term;
                else
                    neg += term;
                term = ((term * t2) >> 30) / d;
            end
            if (neg >= pos)
                return 0;
            pos -= neg;
            return (pos > ONE_Q30) ? ONE_Q30 : pos;
        endfunction

        function logic [AMP_W-1:0] rom_entry(longint unsigned p);
            longint unsigned quad, rem, theta, s, v, e;
            quad  = (4 * p) / TABLE_LEN;
            rem   = (4 * p) % TABLE_LEN;
            theta = (PI_Q30 * rem) / (2 * TABLE_LEN);
            s     = taylor_q30(theta, quad[0]);
            v     = (quad < 2) ? (ONE_Q30 + s) / 2 : (ONE_Q30 - s) / 2;
            e     = (v * 65535 + (64'd1 << 29)) >> 30;
            return (e > 65535) ? pwg_pkg::AMP_MAX : e[AMP_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                pwg_pkg::REG_SHAPE:  shape  = data[SHAPE_W-1:0];
                pwg_pkg::REG_AMP:    amp    = data[AMP_W-1:0];
                pwg_pkg::REG_PERIOD: period = data[IDX_W-1:0];
                default:    ;
            endcase
        endfunction

        function void note_request(bit restart);
            longint unsigned n, half, i, a, p, v;
            dac_word_t       w;
            n    = (period < 2) ? 2 : period;
            half = n / 2;
            a    = amp;
            if (restart || point >= n)
                point = '0;
            i = point;
            case (shape)
                pwg_pkg::SHAPE_SINE:
                begin
                    p = (i * TABLE_LEN) / n;
                    if (p >= TABLE_LEN)
                        p = TABLE_LEN - 1;
                    v = (longint'(sine_rom[p]) * a) / 65535;
                end
                pwg_pkg::SHAPE_SQUARE: v = (i < half) ? 0 : a;
                pwg_pkg::SHAPE_TRI:    v = (i < half) ? (i * a) / half : ((n - 1 - i) * a) / half;
                default:               v = (i * a) / n;
            endcase
            w.sample     = v[AMP_W-1:0];
            w.period_end = (i == n - 1);
            expected_samples.push_back(w);
            point = (i == n - 1) ? '0 : IDX_W'(i + 1);
        endfunction

        function void check_sample(logic [AMP_W-1:0] sample, logic period_end);
            dac_word_t w;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected output word: sample %0d, period_end %0b", sample,
                       period_end);
                errors++;
                return;
            end
            w = expected_samples.pop_front();
            if (sample !== w.sample)
            begin
                $error("sample mismatch: expected %0d, actual %0d", w.sample, sample);
                errors++;
            end
            if (period_end !== w.period_end)
            begin
                $error("period_end mismatch: expected %0b, actual %0b", w.period_end,
                       period_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [0] restart, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [15:0] sample
    logic                   m_tlast;    // period end

    sample_predictor pred;
    int              sent_count = 0;
    bit              calm       = 1'b0;
    bit              src_idle_on = 1'b1;
    bit              rx_idle_on  = 1'b1;

    periodic_waveform_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: stall in random bursts unless the run is in its calm tail.
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rx_idle_on && !calm && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pred != null)
        begin
            if (m_tvalid && m_tready)
                pred.check_sample(m_tdata[AMP_W-1:0], m_tlast);
            if (cfg_valid && cfg_ready)
                pred.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                pred.note_request(s_tdata[0]);
        end
    end

    task automatic send_request(input bit restart);
        @(negedge clk);
        if (src_idle_on && !calm && $urandom_range(0, 9) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_TDATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // Drop valid and hold off until every outstanding word has come back.
    task automatic drain_samples();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pred.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_samples();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        int                    burst;

        pred      = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, then restart from point 0.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // Shortest period on the square wave.
        set_reg(pwg_pkg::REG_SHAPE, CFG_DATA_W'(pwg_pkg::SHAPE_SQUARE));
        set_reg(pwg_pkg::REG_PERIOD, 17'd2);
        repeat (3) send_request(1'b0);

        // Periods of zero and one act as two.
        set_reg(pwg_pkg::REG_PERIOD, 17'd0);
        set_reg(pwg_pkg::REG_SHAPE, CFG_DATA_W'(pwg_pkg::SHAPE_TRI));
        repeat (2) send_request(1'b0);
        set_reg(pwg_pkg::REG_PERIOD, 17'd1);
        set_reg(pwg_pkg::REG_SHAPE, CFG_DATA_W'(pwg_pkg::SHAPE_SAW));
        repeat (2) send_request(1'b0);

        // Zero amplitude sine.
        set_reg(pwg_pkg::REG_AMP, 17'd0);
        set_reg(pwg_pkg::REG_SHAPE, CFG_DATA_W'(pwg_pkg::SHAPE_SINE));
        set_reg(pwg_pkg::REG_PERIOD, 17'd5);
        repeat (2) send_request(1'b0);

        // Amplitude with the spare bit set keeps its low 16 bits; longest period.
        set_reg(pwg_pkg::REG_AMP, 17'h1FFFF);
        set_reg(pwg_pkg::REG_PERIOD, 17'h1FFFF);
        send_request(1'b1);
        repeat (2) send_request(1'b0);

        // Shrink the period below the current index: next word restarts at 0.
        set_reg(pwg_pkg::REG_PERIOD, 17'd2);
        repeat (2) send_request(1'b0);

        // Unused index is dropped; shape keeps its low bits only.
        set_reg(REG_UNUSED, 17'h1ABCD);
        set_reg(pwg_pkg::REG_SHAPE, {15'h7FFF, pwg_pkg::SHAPE_TRI});
        set_reg(pwg_pkg::REG_PERIOD, 17'h1FFFF);
        send_request(1'b1);
        send_request(1'b0);

        while (sent_count < ITEM_TARGET)
        begin
            calm        = (sent_count >= ITEM_TARGET - CALM_ITEMS);
            src_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            drain_samples();
            if ($urandom_range(0, 1) == 0)
                set_reg(pwg_pkg::REG_SHAPE, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       data = 17'd0;
                    1:       data = {1'b0, pwg_pkg::AMP_MAX};
                    default: data = CFG_DATA_W'($urandom);
                endcase
                data[AMP_W] = 1'($urandom_range(0, 1));
                set_reg(pwg_pkg::REG_AMP, data);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       data = 17'd2;
                    1:       data = 17'h1FFFF;
                    2:       data = CFG_DATA_W'($urandom_range(0, 1));
                    3:       data = CFG_DATA_W'($urandom_range(2, 17'h1FFFF));
                    default: data = CFG_DATA_W'($urandom_range(2, 64));
                endcase
                set_reg(pwg_pkg::REG_PERIOD, data);
            end
            if ($urandom_range(0, 5) == 0)
                set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            burst = $urandom_range(20, 80);
            repeat (burst) send_request($urandom_range(0, 15) == 0);
        end

        drain_samples();
        repeat (SETTLE) @(posedge clk);
        if (pred.errors == 0 && pred.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
